// ===== hw/rtl/dda_line_rasterizer_assert.svh =====
// assertion macros shared by the line rasterizer modules
`ifndef DDA_LINE_RASTERIZER_ASSERT_SVH
`define DDA_LINE_RASTERIZER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DDA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dda_pkg.sv =====
// shared types and constants for the dda line rasterizer
package dda_pkg;

    // default geometry
    localparam int COORD_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 16;

    // command codes carried on s_tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // line set-up sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y
    } seq_state_t;

    // divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== hw/rtl/dda_div.sv =====
// shared restoring divider: (dividend << FRAC_BITS) / divisor, one quotient bit a cycle
module dda_div
    import dda_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] dividend,  // never above divisor
    input  logic [COORD_BITS-1:0] divisor,   // non-zero
    output logic [FRAC_BITS:0]    quotient,
    output div_status_t           status
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FRAC_BITS);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [COORD_BITS:0]   rem_reg, rem_next;
    logic [COORD_BITS-1:0] dsr_reg, dsr_next;
    logic [FRAC_BITS:0]    quo_reg, quo_next;

    logic [COORD_BITS:0]   trial;
    logic                  fits;

    // first step takes the integer bit without a shift
    assign trial = (cnt_reg == '0) ? rem_reg : {rem_reg[COORD_BITS-1:0], 1'b0};
    assign fits  = (trial >= {1'b0, dsr_reg});

    // one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = {1'b0, dividend};
            dsr_next  = divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (trial - {1'b0, dsr_reg}) : trial;
            quo_next = {quo_reg[FRAC_BITS-1:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

`include "dda_line_rasterizer_assert.svh"

    `DDA_ASSERT_IMPL(a_no_start_when_busy, clk, rst_n, start, !busy_reg, "divider restarted while busy")
    `DDA_ASSERT_IMPL(a_done_not_busy, clk, rst_n, done_reg, !busy_reg, "divider done while still busy")

endmodule

// ===== hw/rtl/dda_line_rasterizer.sv =====
// dda line rasterizer: load and step sequencer, accumulators and output register
//
// input channel s_*: s_tuser is the command. a load word brings both endpoints
// in s_tdata and returns nothing; a step word returns the next pixel of the
// current line on the m_* channel, with m_tlast on the line's final pixel.
// steps with no line loaded, or after the final pixel, are taken and dropped.
// a load sets the increments with one shared bit-serial divider, x then y,
// while s_tready is low; a zero-length line needs no division and leaves the
// sequencer idle.
// a step is accepted whenever the sequencer is idle and the output register is
// empty or being drained, so pixels flow one per cycle, and m_tvalid rises in
// the cycle after the step word.
// if the receiver stalls, the pixel waits in the output register and s_tready
// drops until it is taken.
// reset clears the accumulators, the increments and the pixel count; no line
// is loaded after reset.
module dda_line_rasterizer
    import dda_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // x_start, y_start, x_end, y_end from the lowest bit, zero padded
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    // command
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // pixel_x, pixel_y from the lowest bit, zero padded
    output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_tdata,
    output logic                                   m_tlast
);

    localparam int ACC_W  = COORD_BITS + FRAC_BITS + 1;
    localparam int INC_W  = FRAC_BITS + 2;
    localparam int CNT_W  = COORD_BITS + 1;
    localparam int MDAT_W = ((2*COORD_BITS+7)/8)*8;
    localparam logic [ACC_W-1:0] HALF_PIXEL = ACC_W'(1) << (FRAC_BITS - 1);

    // sequencer and line state
    seq_state_t              state_reg, state_next;
    logic                    div_go_reg, div_go_next;
    logic [ACC_W-1:0]        xacc_reg, xacc_next;
    logic [ACC_W-1:0]        yacc_reg, yacc_next;
    logic [INC_W-1:0]        xinc_reg, xinc_next;
    logic [INC_W-1:0]        yinc_reg, yinc_next;
    logic [CNT_W-1:0]        remain_reg, remain_next;
    logic                    active_reg, active_next;
    logic [COORD_BITS-1:0]   adx_reg, adx_next;
    logic [COORD_BITS-1:0]   ady_reg, ady_next;
    logic [COORD_BITS-1:0]   len_reg, len_next;
    logic                    xneg_reg, xneg_next;
    logic                    yneg_reg, yneg_next;

    // output register
    logic                    mvalid_reg, mvalid_next;
    logic [COORD_BITS-1:0]   px_reg, px_next;
    logic [COORD_BITS-1:0]   py_reg, py_next;
    logic                    mlast_reg, mlast_next;

    logic                    ready;
    logic                    in_fire;
    logic                    load_fire;
    logic                    step_fire;

    logic [COORD_BITS-1:0]   xs, ys, xe, ye;
    logic [COORD_BITS:0]     dx, dy;
    logic [COORD_BITS-1:0]   adx, ady, len;

    logic [COORD_BITS-1:0]   div_dividend;
    logic [FRAC_BITS:0]      div_quo;
    div_status_t             div_stat;
    logic [INC_W-1:0]        quo_pos, quo_neg;

    logic [COORD_BITS-1:0]   pix_x, pix_y;

    // unpack the input word
    assign xs = s_tdata[COORD_BITS-1:0];
    assign ys = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign xe = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign ye = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

    // deltas, magnitudes and step count
    assign dx  = {1'b0, xe} - {1'b0, xs};
    assign dy  = {1'b0, ye} - {1'b0, ys};
    assign adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    assign ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    assign len = (adx >= ady) ? adx : ady;

    // handshake
    assign in_fire   = s_tvalid && ready;
    assign load_fire = in_fire && (s_tuser == CMD_LOAD);
    assign step_fire = in_fire && (s_tuser == CMD_STEP) && active_reg;

    // shared divider, x first then y
    assign div_dividend = (state_reg == ST_DIV_Y) ? ady_reg : adx_reg;

    dda_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .dividend (div_dividend),
        .divisor  (len_reg),
        .quotient (div_quo),
        .status   (div_stat)
    );

    assign quo_pos = {1'b0, div_quo};
    assign quo_neg = -quo_pos;

    // accumulator truncated toward zero
    function automatic logic [COORD_BITS-1:0] to_pixel(input logic [ACC_W-1:0] acc);
        logic [ACC_W-1:0] mag;
        begin
            mag = -acc;
            if (acc[ACC_W-1])
                to_pixel = -mag[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
            else
                to_pixel = acc[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
        end
    endfunction

    assign pix_x = to_pixel(xacc_reg);
    assign pix_y = to_pixel(yacc_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load_fire && (len != '0))
                    state_next = ST_DIV_X;
            end
            ST_DIV_X:
            begin
                if (div_stat.done)
                    state_next = ST_DIV_Y;
            end
            ST_DIV_Y:
            begin
                if (div_stat.done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:  ready = !mvalid_reg || m_tready;
            ST_DIV_X: ready = 1'b0;
            ST_DIV_Y: ready = 1'b0;
            default:  ready = 1'b0;
        endcase
    end

    // line set-up and stepping
    always_comb
    begin
        div_go_next = 1'b0;
        xacc_next   = xacc_reg;
        yacc_next   = yacc_reg;
        xinc_next   = xinc_reg;
        yinc_next   = yinc_reg;
        remain_next = remain_reg;
        active_next = active_reg;
        adx_next    = adx_reg;
        ady_next    = ady_reg;
        len_next    = len_reg;
        xneg_next   = xneg_reg;
        yneg_next   = yneg_reg;
        if (load_fire)
        begin
            adx_next    = adx;
            ady_next    = ady;
            len_next    = len;
            xneg_next   = dx[COORD_BITS];
            yneg_next   = dy[COORD_BITS];
            xinc_next   = '0;
            yinc_next   = '0;
            div_go_next = (len != '0);
            remain_next = {1'b0, len} + 1'b1;
            active_next = 1'b1;
            // start half a pixel along each delta
            xacc_next = {1'b0, xs, {FRAC_BITS{1'b0}}};
            if (dx[COORD_BITS])
                xacc_next = xacc_next - HALF_PIXEL;
            else if (dx != '0)
                xacc_next = xacc_next + HALF_PIXEL;
            yacc_next = {1'b0, ys, {FRAC_BITS{1'b0}}};
            if (dy[COORD_BITS])
                yacc_next = yacc_next - HALF_PIXEL;
            else if (dy != '0)
                yacc_next = yacc_next + HALF_PIXEL;
        end
        else if (step_fire)
        begin
            remain_next = remain_reg - 1'b1;
            if (remain_reg == CNT_W'(1))
                active_next = 1'b0;
            else
            begin
                xacc_next = xacc_reg + {{(ACC_W-INC_W){xinc_reg[INC_W-1]}}, xinc_reg};
                yacc_next = yacc_reg + {{(ACC_W-INC_W){yinc_reg[INC_W-1]}}, yinc_reg};
            end
        end
        // signed increments from the divider
        if ((state_reg == ST_DIV_X) && div_stat.done)
        begin
            xinc_next   = xneg_reg ? quo_neg : quo_pos;
            div_go_next = 1'b1;
        end
        if ((state_reg == ST_DIV_Y) && div_stat.done)
            yinc_next = yneg_reg ? quo_neg : quo_pos;
    end

    // output register
    always_comb
    begin
        mvalid_next = mvalid_reg && !m_tready;
        px_next     = px_reg;
        py_next     = py_reg;
        mlast_next  = mlast_reg;
        if (step_fire)
        begin
            mvalid_next = 1'b1;
            px_next     = pix_x;
            py_next     = pix_y;
            mlast_next  = (remain_reg == CNT_W'(1));
        end
    end

    // control state and line registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            div_go_reg <= 1'b0;
            xacc_reg   <= '0;
            yacc_reg   <= '0;
            xinc_reg   <= '0;
            yinc_reg   <= '0;
            remain_reg <= '0;
            active_reg <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            div_go_reg <= div_go_next;
            xacc_reg   <= xacc_next;
            yacc_reg   <= yacc_next;
            xinc_reg   <= xinc_next;
            yinc_reg   <= yinc_next;
            remain_reg <= remain_next;
            active_reg <= active_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        adx_reg   <= adx_next;
        ady_reg   <= ady_next;
        len_reg   <= len_next;
        xneg_reg  <= xneg_next;
        yneg_reg  <= yneg_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        mlast_reg <= mlast_next;
    end

    assign s_tready = ready;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = MDAT_W'({py_reg, px_reg});
    assign m_tlast  = mlast_reg;

`include "dda_line_rasterizer_assert.svh"

    `DDA_ASSERT_IMPL(a_ready_only_idle, clk, rst_n, s_tready, state_reg == ST_IDLE,
                     "ready while setting up a line")
    `DDA_ASSERT_IMPL(a_active_count, clk, rst_n, 1'b1, active_reg == (remain_reg != '0),
                     "line active flag disagrees with pixel count")
    `DDA_ASSERT_NEXT(a_step_gives_word, clk, rst_n, step_fire, m_tvalid,
                     "served step gave no output word")
    `DDA_ASSERT_NEXT(a_div_go_setup, clk, rst_n, div_go_reg,
                     (state_reg == ST_DIV_X) || (state_reg == ST_DIV_Y),
                     "divider started outside line set-up")

endmodule
